// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the feather edge blend checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define FEB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("feather edge blend assertion failed");

// checked on every edge, reset included
`define FEB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("feather edge blend assertion failed");

`endif

// ----- hdl/feb_pkg.sv -----
// ----------------------------------------------------------------------------
// feb_pkg
// Types and constants shared by the feather edge blend modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package feb_pkg;

  localparam int MAX_TILE_SIDE = 4096;

  localparam int POS_W     = 12;
  localparam int SIDE_W    = 13;
  localparam int SDIST_W   = SIDE_W + 1;
  localparam int BWIDTH_W  = 11;
  localparam int Q16_W     = 17;
  localparam int PIX_W     = 8;
  localparam int CH_N      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int WPROD_W   = POS_W + Q16_W;
  localparam int CPROD_W   = PIX_W + Q16_W;

  localparam logic [Q16_W-1:0]  Q16_ONE  = Q16_W'(65536);
  localparam logic [Q16_W-1:0]  Q16_HALF = Q16_W'(32768);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_TILE_SIDE);

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WIDTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_RECIP = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COPY_DIRECT = CFG_IDX_W'(4);

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] view_red;
    logic [PIX_W-1:0] view_green;
    logic [PIX_W-1:0] view_blue;
    logic [PIX_W-1:0] canvas_red;
    logic [PIX_W-1:0] canvas_green;
    logic [PIX_W-1:0] canvas_blue;
  } feb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [Q16_W-1:0] blend_weight;
  } feb_out_t;

  typedef struct packed {
    logic [SIDE_W-1:0]   tile_width;
    logic [SIDE_W-1:0]   tile_height;
    logic [BWIDTH_W-1:0] blend_width;
    logic [Q16_W-1:0]    blend_recip;
    logic                copy_direct;
  } feb_cfg_t;

  typedef struct packed {
    logic [Q16_W-1:0]           weight;
    logic [CH_N-1:0][PIX_W-1:0] view;
    logic [CH_N-1:0][PIX_W-1:0] canvas;
  } feb_wt_t;

endpackage

// ----- hdl/feb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// feb_cfg_regs
// Configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [feb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [feb_pkg::CFG_DAT_W-1:0] cfg_data,
  output feb_pkg::feb_cfg_t             cfg
);
  import feb_pkg::*;

  feb_cfg_t cfg_r;
  feb_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TILE_WIDTH:  cfg_nxt.tile_width  = cfg_data[SIDE_W-1:0];
        REG_TILE_HEIGHT: cfg_nxt.tile_height = cfg_data[SIDE_W-1:0];
        REG_BLEND_WIDTH: cfg_nxt.blend_width = cfg_data[BWIDTH_W-1:0];
        REG_BLEND_RECIP: cfg_nxt.blend_recip = cfg_data[Q16_W-1:0];
        REG_COPY_DIRECT: cfg_nxt.copy_direct = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_width  <= SIDE_W'(1024);
      cfg_r.tile_height <= SIDE_W'(1024);
      cfg_r.blend_width <= BWIDTH_W'(256);
      cfg_r.blend_recip <= Q16_W'(256);
      cfg_r.copy_direct <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/feb_edge_weight.sv -----
// ----------------------------------------------------------------------------
// feb_edge_weight
// Two pipeline stages: edge distance, then ramp weight with saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feb_edge_weight (
  input  logic              clk,
  input  logic              rst_n,
  input  feb_pkg::feb_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  feb_pkg::feb_in_t  in_data,
  output logic              wt_valid,
  input  logic              wt_ready,
  output feb_pkg::feb_wt_t  wt_data
);
  import feb_pkg::*;

  localparam logic signed [SDIST_W-1:0] ONE_S = SDIST_W'(1);

  logic                       s1_v_r;
  logic [POS_W-1:0]           s1_d_r;
  logic [CH_N-1:0][PIX_W-1:0] s1_view_r;
  logic [CH_N-1:0][PIX_W-1:0] s1_canvas_r;
  logic                       s2_v_r;
  feb_wt_t                    s2_data_r;

  logic                       s1_ready;
  logic                       s2_ready;
  logic [SIDE_W-1:0]          w_side;
  logic [SIDE_W-1:0]          h_side;
  logic signed [SDIST_W-1:0]  dx0, dx1, dy0, dy1, mx, my, dmin;
  logic [POS_W-1:0]           d_nxt;
  logic                       full_w;
  logic [WPROD_W-1:0]         ramp;
  logic [Q16_W-1:0]           weight_nxt;

  assign s2_ready = !s2_v_r || wt_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;
  assign wt_valid = s2_v_r;
  assign wt_data  = s2_data_r;

  // stage 1: distance to the nearest tile edge
  always_comb begin
    w_side = (cfg.tile_width > SIDE_MAX) ? SIDE_MAX : cfg.tile_width;
    h_side = (cfg.tile_height > SIDE_MAX) ? SIDE_MAX : cfg.tile_height;
    dx0    = $signed({{(SDIST_W-POS_W){1'b0}}, in_data.pos_x});
    dy0    = $signed({{(SDIST_W-POS_W){1'b0}}, in_data.pos_y});
    dx1    = $signed({1'b0, w_side}) - ONE_S - dx0;
    dy1    = $signed({1'b0, h_side}) - ONE_S - dy0;
    mx     = (dx0 < dx1) ? dx0 : dx1;
    my     = (dy0 < dy1) ? dy0 : dy1;
    dmin   = (mx < my) ? mx : my;
    d_nxt  = dmin[SDIST_W-1] ? '0 : dmin[POS_W-1:0];
  end

  // stage 2: ramp weight
  always_comb begin
    full_w = cfg.copy_direct || (cfg.blend_width == '0) ||
             (s1_d_r >= POS_W'(cfg.blend_width));
    ramp   = WPROD_W'(s1_d_r) * WPROD_W'(cfg.blend_recip);
    if (full_w || (ramp > WPROD_W'(Q16_ONE))) begin
      weight_nxt = Q16_ONE;
    end else begin
      weight_nxt = ramp[Q16_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_d_r      <= d_nxt;
      s1_view_r   <= {in_data.view_red, in_data.view_green, in_data.view_blue};
      s1_canvas_r <= {in_data.canvas_red, in_data.canvas_green, in_data.canvas_blue};
    end
    if (s2_ready && s1_v_r) begin
      s2_data_r.weight <= weight_nxt;
      s2_data_r.view   <= s1_view_r;
      s2_data_r.canvas <= s1_canvas_r;
    end
  end

endmodule

// ----- hdl/feb_channel_mix.sv -----
// ----------------------------------------------------------------------------
// feb_channel_mix
// Two pipeline stages: per-channel weighted products, then rounded sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feb_channel_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wt_valid,
  output logic              wt_ready,
  input  feb_pkg::feb_wt_t  wt_data,
  output logic              out_valid,
  input  logic              out_ready,
  output feb_pkg::feb_out_t out_data
);
  import feb_pkg::*;

  localparam int SUM_W = CPROD_W + 1;

  logic                         s3_v_r;
  logic [CH_N-1:0][CPROD_W-1:0] s3_pv_r;
  logic [CH_N-1:0][CPROD_W-1:0] s3_pc_r;
  logic [Q16_W-1:0]             s3_w_r;
  logic                         s4_v_r;
  feb_out_t                     s4_data_r;

  logic                         s3_ready;
  logic                         s4_ready;
  logic [Q16_W-1:0]             inv_w;
  logic [CH_N-1:0][CPROD_W-1:0] pv_nxt;
  logic [CH_N-1:0][CPROD_W-1:0] pc_nxt;
  logic [CH_N-1:0][SUM_W-1:0]   sum;
  feb_out_t                     out_nxt;

  assign s4_ready  = !s4_v_r || out_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign wt_ready  = s3_ready;
  assign out_valid = s4_v_r;
  assign out_data  = s4_data_r;

  assign inv_w = Q16_ONE - wt_data.weight;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      pv_nxt[c] = CPROD_W'(wt_data.view[c]) * CPROD_W'(wt_data.weight);
      pc_nxt[c] = CPROD_W'(wt_data.canvas[c]) * CPROD_W'(inv_w);
      sum[c]    = SUM_W'(s3_pv_r[c]) + SUM_W'(s3_pc_r[c]) + SUM_W'(Q16_HALF);
    end
    out_nxt.out_red      = sum[2][16 +: PIX_W];
    out_nxt.out_green    = sum[1][16 +: PIX_W];
    out_nxt.out_blue     = sum[0][16 +: PIX_W];
    out_nxt.blend_weight = s3_w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_r <= wt_valid;
      end
      if (s4_ready) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && wt_valid) begin
      s3_pv_r <= pv_nxt;
      s3_pc_r <= pc_nxt;
      s3_w_r  <= wt_data.weight;
    end
    if (s4_ready && s3_v_r) begin
      s4_data_r <= out_nxt;
    end
  end

endmodule

// ----- hdl/feather_edge_blend_top.sv -----
// ----------------------------------------------------------------------------
// feather_edge_blend_top
// Feather blend of a view tile pixel onto a canvas tile pixel
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one blended word per clock
// while out_ready stays high. A word passes four register stages (edge
// distance, ramp weight, channel products, rounded sum) before its result
// shows on out_valid. Every stage holds its word under backpressure and
// in_ready only drops once all four stages are full. Configuration writes
// take effect on the next cycle and are meant to be made while no pixel is
// in flight.
`timescale 1ns / 1ps

module feather_edge_blend_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  feb_pkg::feb_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output feb_pkg::feb_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [feb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [feb_pkg::CFG_DAT_W-1:0] cfg_data
);
  import feb_pkg::*;

  feb_cfg_t cfg;
  logic     wt_valid;
  logic     wt_ready;
  feb_wt_t  wt_data;

  feb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  feb_edge_weight u_edge_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wt_valid (wt_valid),
    .wt_ready (wt_ready),
    .wt_data  (wt_data)
  );

  feb_channel_mix u_channel_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .wt_valid  (wt_valid),
    .wt_ready  (wt_ready),
    .wt_data   (wt_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/feb_checker.sv -----
// ----------------------------------------------------------------------------
// feb_checker
// Port-level assertions for the feather edge blend top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module feb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input feb_pkg::feb_out_t out_data
);
  import feb_pkg::*;

  // no result word right after reset
  `FEB_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)

  // a stalled result word holds
  `FEB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // input only stalls when the output side is full and stalled
  `FEB_ASSERT(a_in_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready)

  // four-stage latency with a free-running sink
  `FEB_ASSERT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)

  // weight stays within Q16 one
  `FEB_ASSERT(a_weight_range, clk, rst_n, out_valid |-> out_data.blend_weight <= Q16_ONE)

endmodule

bind feather_edge_blend_top feb_checker u_feb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/feather_edge_blend_top_tb.sv -----
// ----------------------------------------------------------------------------
// feather_edge_blend_top_tb
// Self-checking bench for the feather edge blend pipeline
// ----------------------------------------------------------------------------
// A directed table covers reset values, tile corners and centers, positions
// outside the tile, a zero band, oversized and empty tiles, saturating and
// inconsistent weight steps, and direct copy. Random phases follow with new
// register settings each, edge-biased pixel positions, and sender and
// receiver idling, including a long receiver hold that backs the pipe up.
// Every result word is checked against a table value or a local blend predictor.
`timescale 1ns / 1ps

module feather_edge_blend_top_tb;
  import feb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 60;
  localparam int N_PHASES       = 8;
  localparam int SHOW_LIMIT     = 10;

  typedef enum {ROW_CFG, ROW_KNOWN, ROW_OPEN} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] val;
    feb_in_t              px;
    feb_out_t             res;
  } dir_row_t;

  typedef struct {
    feb_in_t  px;
    feb_out_t res;
  } pixel_job_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  feb_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  feb_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  feb_cfg_t   cfg_now;
  dir_row_t   dir_rows[$];
  pixel_job_t pixel_jobs[$];
  feb_out_t   blend_due[$];
  pixel_job_t offered;
  feb_out_t   want;
  int         mismatches     = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         rx_hold        = 1'b0;
  int         quiet;

  feather_edge_blend_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] weigh_channel(logic [PIX_W-1:0] v,
                                                     logic [PIX_W-1:0] c,
                                                     logic [Q16_W-1:0] w);
    logic [41:0] acc;
    acc = 42'(v) * 42'(w) + 42'(c) * (42'(Q16_ONE) - 42'(w)) + 42'(Q16_HALF);
    return acc[23:16];
  endfunction

  function automatic feb_out_t blend_pixel(feb_in_t px);
    int               side_w, side_h, cx, cy, edge_d, band;
    longint           step, ramp;
    logic [Q16_W-1:0] wt;
    feb_out_t         r;
    if (cfg_now.copy_direct) begin
      r.out_red      = px.view_red;
      r.out_green    = px.view_green;
      r.out_blue     = px.view_blue;
      r.blend_weight = Q16_ONE;
      return r;
    end
    side_w = cfg_now.tile_width;
    side_h = cfg_now.tile_height;
    if (side_w > MAX_TILE_SIDE) side_w = MAX_TILE_SIDE;
    if (side_h > MAX_TILE_SIDE) side_h = MAX_TILE_SIDE;
    cx   = px.pos_x;
    cy   = px.pos_y;
    band = cfg_now.blend_width;
    step = cfg_now.blend_recip;
    edge_d = cx;
    if (side_w - 1 - cx < edge_d) edge_d = side_w - 1 - cx;
    if (cy < edge_d) edge_d = cy;
    if (side_h - 1 - cy < edge_d) edge_d = side_h - 1 - cy;
    if (edge_d < 0) edge_d = 0;
    if (band == 0 || edge_d >= band) begin
      wt = Q16_ONE;
    end else begin
      ramp = edge_d * step;
      wt   = (ramp > 65536) ? Q16_ONE : Q16_W'(ramp);
    end
    r.out_red      = weigh_channel(px.view_red, px.canvas_red, wt);
    r.out_green    = weigh_channel(px.view_green, px.canvas_green, wt);
    r.out_blue     = weigh_channel(px.view_blue, px.canvas_blue, wt);
    r.blend_weight = wt;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_coord(int side, int band);
    int lim, off;
    lim = (side > MAX_TILE_SIDE) ? MAX_TILE_SIDE : side;
    if (lim < 1) lim = 1;
    off = $urandom_range(band + 1, 0);
    case ($urandom_range(9))
      0: return POS_W'($urandom_range(4095));
      1, 2, 3, 4: return POS_W'($urandom_range(lim - 1, 0));
      5, 6: return POS_W'((off > lim - 1) ? lim - 1 : off);
      default: return POS_W'((lim - 1 - off < 0) ? 0 : lim - 1 - off);
    endcase
  endfunction

  function automatic feb_in_t mk_px(int x, int y, int vr, int vg, int vb,
                                    int cr, int cg, int cb);
    feb_in_t p;
    p.pos_x        = POS_W'(x);
    p.pos_y        = POS_W'(y);
    p.view_red     = PIX_W'(vr);
    p.view_green   = PIX_W'(vg);
    p.view_blue    = PIX_W'(vb);
    p.canvas_red   = PIX_W'(cr);
    p.canvas_green = PIX_W'(cg);
    p.canvas_blue  = PIX_W'(cb);
    return p;
  endfunction

  function automatic feb_out_t mk_res(int r, int g, int b, logic [Q16_W-1:0] w);
    feb_out_t o;
    o.out_red      = PIX_W'(r);
    o.out_green    = PIX_W'(g);
    o.out_blue     = PIX_W'(b);
    o.blend_weight = w;
    return o;
  endfunction

  task automatic row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    row.px   = '0;
    row.res  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic row_known(feb_in_t px, feb_out_t res);
    dir_row_t row;
    row.kind = ROW_KNOWN;
    row.idx  = '0;
    row.val  = '0;
    row.px   = px;
    row.res  = res;
    dir_rows.push_back(row);
  endtask

  task automatic row_open(feb_in_t px);
    dir_row_t row;
    row.kind = ROW_OPEN;
    row.idx  = '0;
    row.val  = '0;
    row.px   = px;
    row.res  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic queue_pixel(feb_in_t px, feb_out_t res);
    pixel_job_t job;
    job.px  = px;
    job.res = res;
    pixel_jobs.push_back(job);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_jobs.size() != 0 || in_valid || blend_due.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TILE_WIDTH:  cfg_now.tile_width  = val[SIDE_W-1:0];
      REG_TILE_HEIGHT: cfg_now.tile_height = val[SIDE_W-1:0];
      REG_BLEND_WIDTH: cfg_now.blend_width = val[BWIDTH_W-1:0];
      REG_BLEND_RECIP: cfg_now.blend_recip = val[Q16_W-1:0];
      REG_COPY_DIRECT: cfg_now.copy_direct = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // input driver, result checker and receiver ready in one process
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) blend_due.push_back(offered.res);
      if (!in_valid || in_ready) begin
        if (pixel_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pixel_jobs.pop_front();
          in_valid <= 1'b1;
          in_data  <= offered.px;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (blend_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("unexpected word: r=%0d g=%0d b=%0d w=%0d", out_data.out_red,
                     out_data.out_green, out_data.out_blue, out_data.blend_weight);
        end else begin
          want = blend_due.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("mismatch: want %0d %0d %0d w=%0d, got %0d %0d %0d w=%0d",
                       want.out_red, want.out_green, want.out_blue, want.blend_weight,
                       out_data.out_red, out_data.out_green, out_data.out_blue,
                       out_data.blend_weight);
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet = 0;
    do begin
      @(posedge clk);
      if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) ||
                     (cfg_valid && cfg_ready)))
        quiet++;
      else
        quiet = 0;
    end while (quiet < WATCHDOG_LIMIT);
    $display("feather_edge_blend_top_tb: done, errors");
    $finish;
  end

  initial begin
    int               ph, n, tw, th, bw, br, cd;
    feb_in_t          px;
    cfg_now.tile_width  = SIDE_W'(1024);
    cfg_now.tile_height = SIDE_W'(1024);
    cfg_now.blend_width = BWIDTH_W'(256);
    cfg_now.blend_recip = Q16_W'(256);
    cfg_now.copy_direct = 1'b0;

    // reset values, corners, center, band edge, outside the tile
    row_known(mk_px(0, 0, 255, 255, 255, 0, 0, 0), mk_res(0, 0, 0, 0));
    row_known(mk_px(512, 512, 255, 0, 128, 1, 2, 3), mk_res(255, 0, 128, Q16_ONE));
    row_known(mk_px(1023, 1023, 200, 100, 50, 10, 20, 30), mk_res(10, 20, 30, 0));
    row_known(mk_px(4095, 4095, 255, 255, 255, 0, 128, 255), mk_res(0, 128, 255, 0));
    row_open(mk_px(100, 300, 255, 255, 255, 0, 0, 0));
    row_open(mk_px(128, 512, 1, 0, 255, 0, 1, 254));
    row_open(mk_px(255, 600, 0, 0, 0, 255, 255, 255));
    row_known(mk_px(256, 600, 17, 34, 51, 0, 0, 0), mk_res(17, 34, 51, Q16_ONE));
    // zero band
    row_cfg(REG_BLEND_WIDTH, 0);
    row_known(mk_px(0, 0, 9, 8, 7, 1, 2, 3), mk_res(9, 8, 7, Q16_ONE));
    // step that saturates
    row_cfg(REG_BLEND_WIDTH, 1024);
    row_cfg(REG_BLEND_RECIP, 65536);
    row_known(mk_px(0, 5, 255, 255, 255, 4, 5, 6), mk_res(4, 5, 6, 0));
    row_known(mk_px(2, 500, 60, 70, 80, 0, 0, 0), mk_res(60, 70, 80, Q16_ONE));
    row_known(mk_px(1, 500, 60, 70, 80, 0, 0, 0), mk_res(60, 70, 80, Q16_ONE));
    // step that does not match the band
    row_cfg(REG_BLEND_RECIP, 0);
    row_known(mk_px(300, 300, 255, 255, 255, 11, 22, 33), mk_res(11, 22, 33, 0));
    row_cfg(REG_BLEND_WIDTH, 2047);
    row_cfg(REG_BLEND_RECIP, 131071);
    row_known(mk_px(1, 10, 0, 0, 0, 255, 255, 255), mk_res(0, 0, 0, Q16_ONE));
    // oversized, empty and single pixel tiles
    row_cfg(REG_TILE_WIDTH, 8191);
    row_cfg(REG_TILE_HEIGHT, 4096);
    row_cfg(REG_BLEND_WIDTH, 256);
    row_cfg(REG_BLEND_RECIP, 256);
    row_known(mk_px(4095, 2048, 255, 255, 255, 7, 7, 7), mk_res(7, 7, 7, 0));
    row_known(mk_px(2048, 2048, 1, 2, 3, 0, 0, 0), mk_res(1, 2, 3, Q16_ONE));
    row_cfg(REG_TILE_HEIGHT, 0);
    row_known(mk_px(2048, 2048, 1, 2, 3, 40, 50, 60), mk_res(40, 50, 60, 0));
    row_cfg(REG_TILE_WIDTH, 1);
    row_cfg(REG_TILE_HEIGHT, 1);
    row_known(mk_px(0, 0, 255, 255, 255, 100, 100, 100), mk_res(100, 100, 100, 0));
    // direct copy
    row_cfg(REG_COPY_DIRECT, 1);
    row_known(mk_px(0, 0, 255, 0, 255, 0, 255, 0), mk_res(255, 0, 255, Q16_ONE));
    row_known(mk_px(4095, 4095, 0, 255, 0, 255, 0, 255), mk_res(0, 255, 0, Q16_ONE));
    row_cfg(REG_COPY_DIRECT, 0);
    row_open(mk_px(0, 0, 90, 91, 92, 3, 4, 5));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 22;
    recv_stall_pct = 22;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          cfg_write(dir_rows[i].idx, dir_rows[i].val);
        end
        ROW_KNOWN: queue_pixel(dir_rows[i].px, dir_rows[i].res);
        default:   queue_pixel(dir_rows[i].px, blend_pixel(dir_rows[i].px));
      endcase
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin tw = 1024; th = 1024; bw = 256;  br = 256;    cd = 0; end
        1: begin tw = 1;    th = 1;    bw = 1;    br = 65536;  cd = 0; end
        2: begin tw = 4096; th = 4096; bw = 1024; br = 64;     cd = 0; end
        3: begin tw = 8191; th = 8191; bw = 2047; br = 131071; cd = 0; end
        default: begin
          tw = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(4096, 1);
          th = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(4096, 1);
          if ($urandom_range(5) == 0) tw = $urandom_range(8191);
          if ($urandom_range(5) == 0) th = $urandom_range(8191);
          bw = ($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(1024);
          if (bw == 0 || $urandom_range(4) == 0) br = $urandom_range(131071);
          else br = 65536 / bw;
          cd = (ph == 4) ? 1 : ($urandom_range(5) == 0);
        end
      endcase
      cfg_write(REG_TILE_WIDTH, CFG_DAT_W'(tw));
      cfg_write(REG_TILE_HEIGHT, CFG_DAT_W'(th));
      cfg_write(REG_BLEND_WIDTH, CFG_DAT_W'(bw));
      cfg_write(REG_BLEND_RECIP, CFG_DAT_W'(br));
      cfg_write(REG_COPY_DIRECT, CFG_DAT_W'(cd));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 5) begin
        // long receiver hold while words keep coming, pipe fills and stalls
        fork
          begin
            rx_hold = 1'b1;
            repeat (RX_HOLD_CYCLES) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        px.pos_x        = pick_coord(cfg_now.tile_width, cfg_now.blend_width);
        px.pos_y        = pick_coord(cfg_now.tile_height, cfg_now.blend_width);
        px.view_red     = PIX_W'($urandom_range(255));
        px.view_green   = PIX_W'($urandom_range(255));
        px.view_blue    = PIX_W'($urandom_range(255));
        px.canvas_red   = PIX_W'($urandom_range(255));
        px.canvas_green = PIX_W'($urandom_range(255));
        px.canvas_blue  = PIX_W'($urandom_range(255));
        queue_pixel(px, blend_pixel(px));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += blend_due.size();
    if (mismatches == 0)
      $display("feather_edge_blend_top_tb: done, clean");
    else
      $display("feather_edge_blend_top_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/feb_pkg.sv
hdl/feb_cfg_regs.sv
hdl/feb_edge_weight.sv
hdl/feb_channel_mix.sv
hdl/feather_edge_blend_top.sv
hdl/feb_checker.sv
tb/feather_edge_blend_top_tb.sv
